>>> design/fir_pkg.sv
// ----------------------------------------------------------------------------
// fir_pkg
// shared types and constants of the direct-form fir filter
// ----------------------------------------------------------------------------
package fir_pkg;
    localparam int unsigned DATA_W    = 16;
    localparam int unsigned CNT_W     = 6;
    localparam int unsigned IDX_W     = 5;
    localparam int unsigned ACC_W     = 48;
    localparam logic [CNT_W-1:0] TAP_COUNT_RESET = 6'd21;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_LOAD   = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MUL,
        ST_ACC,
        ST_ROUND,
        ST_OUT
    } state_t;
endpackage

>>> design/fir_filter_direct_form.sv
// ----------------------------------------------------------------------------
// fir_filter_direct_form
// direct-form fir filter with a serial multiply-accumulate over the taps
// ----------------------------------------------------------------------------
// usage
//   input channel s_*: one word per cycle offered with s_valid / s_ready.
//   s_operation selects a sample word (filter) or a coefficient-load word.
//   a load word writes one tap and gives no result.
//   a sample word is shifted into the delay line, then the taps are
//   visited one per pass; each pass reads delay and coefficient memories,
//   forms a 16x16 product bit-serially (one multiplier bit a cycle,
//   shift-and-add) and adds it to a 48-bit accumulator.
//   the bit-serial multiplier forms one product at a time, so the taps
//   of a sample word are processed one after another.
//   output channel m_*: result held in an output register until m_ready;
//   the next word is taken only after the result has gone.
//   tap_wr_en writes tap_count at once; write only while idle.
//   reset: memories are cleared by a sweep of MAX_TAPS cycles, during which
//   s_ready is low; tap_count returns to 21.
// ----------------------------------------------------------------------------
module fir_filter_direct_form #(
    parameter int MAX_TAPS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          tap_wr_en,
    input  logic [fir_pkg::CNT_W-1:0]     tap_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic signed [15:0]            s_sample_in,
    input  logic [fir_pkg::IDX_W-1:0]     s_coef_index,
    input  logic signed [15:0]            s_coef_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [15:0]            m_sample_out,
    output logic                          m_saturated
);
    import fir_pkg::*;

    localparam int AW = $clog2(MAX_TAPS);
    localparam int PW = $clog2(MAX_TAPS + 1);
    localparam logic [PW-1:0] MAX_P = PW'(MAX_TAPS);

    // memories: delay line as a circular buffer, coefficient store
    logic signed [DATA_W-1:0] dly_mem [MAX_TAPS];
    logic signed [DATA_W-1:0] coef_mem [MAX_TAPS];

    state_t state_reg, state_next;
    logic [CNT_W-1:0] tap_count_reg;
    logic           clr_busy_reg;
    logic [AW-1:0]  clr_ptr_reg;
    logic [AW-1:0]  head_reg;     // position of newest sample
    logic [PW-1:0]  k_reg;        // tap being processed
    logic [PW-1:0]  taps_reg;
    logic [4:0]     bit_reg;
    logic signed [DATA_W-1:0] d_rd_reg, c_rd_reg;
    logic [DATA_W-1:0] mplr_reg;       // multiplier bits, shifted out lsb first
    logic signed [31:0] mcand_reg;     // multiplicand, shifted left each cycle
    logic signed [31:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [DATA_W-1:0] out_reg;
    logic           sat_reg;

    logic s_fire, m_fire;
    logic [PW-1:0] taps_lim;
    logic [AW-1:0] head_dec;
    logic [AW:0]   rd_sum;
    logic [AW-1:0] rd_addr;
    logic signed [ACC_W-1:0] rnd_sum, rnd_q;

    assign s_fire   = s_valid && s_ready;
    assign m_fire   = m_valid && m_ready;
    assign taps_lim = (int'(tap_count_reg) > MAX_TAPS) ? MAX_P : PW'(tap_count_reg);
    // circular addressing, wraps at MAX_TAPS
    assign head_dec = (head_reg == '0) ? AW'(MAX_TAPS - 1) : head_reg - AW'(1);
    assign rd_sum   = {1'b0, head_reg} + {1'b0, k_reg[AW-1:0]};
    assign rd_addr  = (rd_sum >= (AW+1)'(MAX_TAPS)) ? rd_sum[AW-1:0] - AW'(MAX_TAPS)
                                                    : rd_sum[AW-1:0];
    assign rnd_sum  = acc_reg + ACC_W'(16384);
    assign rnd_q    = rnd_sum >>> 15;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_operation == OP_SAMPLE) begin
                    state_next = (taps_lim == '0) ? ST_ROUND : ST_FETCH;
                end
            end
            ST_FETCH: state_next = ST_MUL;
            ST_MUL: begin
                if (bit_reg == 5'd15) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:   state_next = (k_reg + PW'(1) == taps_reg) ? ST_ROUND : ST_FETCH;
            ST_ROUND: state_next = ST_OUT;
            ST_OUT: begin
                if (m_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready = (state_reg == ST_IDLE) && !clr_busy_reg;
        m_valid = (state_reg == ST_OUT);
    end
    assign m_sample_out = out_reg;
    assign m_saturated  = sat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tap_count_reg <= TAP_COUNT_RESET;
            clr_busy_reg  <= 1'b1;
            clr_ptr_reg   <= '0;
            head_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (tap_wr_en) begin
                tap_count_reg <= tap_wr_data;
            end
            if (clr_busy_reg) begin
                clr_ptr_reg <= clr_ptr_reg + AW'(1);
                if (clr_ptr_reg == AW'(MAX_TAPS - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (s_fire && s_operation == OP_SAMPLE) begin
                head_reg <= head_dec;
            end
        end
    end

    // memory writes
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            dly_mem[clr_ptr_reg]  <= '0;
            coef_mem[clr_ptr_reg] <= '0;
        end else if (s_fire) begin
            if (s_operation == OP_SAMPLE) begin
                dly_mem[head_dec] <= s_sample_in;
            end else if (int'(s_coef_index) < MAX_TAPS) begin
                coef_mem[AW'(s_coef_index)] <= s_coef_value;
            end
        end
    end

    // registered memory reads
    always_ff @(posedge aclk) begin
        d_rd_reg <= dly_mem[rd_addr];
        c_rd_reg <= coef_mem[k_reg[AW-1:0]];
    end

    // datapath: bit-serial shift-and-add multiplier and accumulator
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                k_reg    <= '0;
                taps_reg <= taps_lim;
                acc_reg  <= '0;
            end
            ST_FETCH: begin
                bit_reg   <= '0;
                prod_reg  <= '0;
            end
            ST_MUL: begin
                if (bit_reg == 5'd0) begin
                    mcand_reg <= 32'(d_rd_reg) <<< 1;
                    mplr_reg  <= c_rd_reg >> 1;
                    prod_reg  <= c_rd_reg[0] ? 32'(d_rd_reg) : '0;
                end else begin
                    mcand_reg <= mcand_reg <<< 1;
                    mplr_reg  <= mplr_reg >> 1;
                    // top multiplier bit carries negative weight
                    if (mplr_reg[0]) begin
                        prod_reg <= (bit_reg == 5'd15) ? prod_reg - mcand_reg
                                                       : prod_reg + mcand_reg;
                    end
                end
                bit_reg <= bit_reg + 5'd1;
            end
            ST_ACC: begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
                k_reg   <= k_reg + PW'(1);
            end
            ST_ROUND: begin
                if (rnd_q > ACC_W'(32767)) begin
                    out_reg <= 16'sh7fff;
                    sat_reg <= 1'b1;
                end else if (rnd_q < -ACC_W'(32768)) begin
                    out_reg <= -16'sh8000;
                    sat_reg <= 1'b1;
                end else begin
                    out_reg <= rnd_q[15:0];
                    sat_reg <= 1'b0;
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("word accepted while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_sample_out)))
        else $error("result changed under stall");
    a_k_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FETCH) |-> (k_reg < taps_reg))
        else $error("tap index beyond count");
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !s_ready)
        else $error("accepted during clearing");
`endif
endmodule
